### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the sample frame deframer
// Field widths of the link word and the result beat, and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned DIG_W    = 8;

  // result kinds
  localparam logic KIND_SAMPLE    = 1'b0;
  localparam logic KIND_OVERSIZE  = 1'b1;

  // link word fields
  localparam int unsigned HEADER_FLAG_BIT = 15;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample_value;
    logic                frame_last;
    logic [DIG_W-1:0]    digital_bits;
    logic [LEN_W-1:0]    header_length;
  } result_t;

endpackage

### rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if: valid/ready channels of the deframer
// Input channel carries one link word a beat, output channel one result.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic                         valid;
  logic                         ready;
  logic [sfd_pkg::WORD_W-1:0]   link_word;

  modport source (output valid, output link_word, input ready);
  modport sink   (input valid, input link_word, output ready);
endinterface

interface sfd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sfd_pkg::SAMPLE_W-1:0] sample_value;
  logic                         frame_last;
  logic [sfd_pkg::DIG_W-1:0]    digital_bits;
  logic [sfd_pkg::LEN_W-1:0]    header_length;

  modport source (output valid, output kind, output sample_value, output frame_last,
                  output digital_bits, output header_length, input ready);
  modport sink   (input valid, input kind, input sample_value, input frame_last,
                  input digital_bits, input header_length, output ready);
endinterface

### rtl/sfd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_frame_ctrl: header hunt, frame count and digital-input assembly
// Holds the framing state; for each accepted word it produces at most one
// result combinationally and updates the state at the clock edge.
// ----------------------------------------------------------------------------
module sfd_frame_ctrl #(
  parameter int unsigned MAX_FRAME_WORDS = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [sfd_pkg::WORD_W-1:0]   word,
  output logic                         res_valid,
  output sfd_pkg::result_t             res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_WORDS + 1);

  logic                      in_payload_r, in_payload_nxt;
  logic [CNT_W-1:0]          words_left_r, words_left_nxt;
  logic [1:0]                word_pos_r, word_pos_nxt;
  logic [sfd_pkg::DIG_W-1:0] dig_accum_r, dig_accum_nxt;
  logic [sfd_pkg::DIG_W-1:0] dig_latest_r, dig_latest_nxt;

  logic [sfd_pkg::LEN_W-1:0] hdr_len;
  logic [2:0]                dig_field;
  logic [sfd_pkg::DIG_W-1:0] dig_merge;
  logic                      last;

  assign hdr_len   = word[sfd_pkg::LEN_W-1:0];
  assign dig_field = word[14:12];

  // place the digital bits by word position within the frame; the third word gives only its upper two
  always_comb begin
    case (word_pos_r)
      2'd0:    dig_merge = {dig_field, 5'b0};
      2'd1:    dig_merge = {3'b0, dig_field, 2'b0};
      2'd2:    dig_merge = {6'b0, dig_field[2:1]};
      default: dig_merge = '0;
    endcase
  end

  assign last = (words_left_r <= CNT_W'(1));

  // next state and result
  always_comb begin
    in_payload_nxt = in_payload_r;
    words_left_nxt = words_left_r;
    word_pos_nxt   = word_pos_r;
    dig_accum_nxt  = dig_accum_r;
    dig_latest_nxt = dig_latest_r;
    res_valid      = 1'b0;
    res            = '0;

    if (step) begin
      if (!in_payload_r) begin
        if (word[sfd_pkg::HEADER_FLAG_BIT]) begin
          if (hdr_len > sfd_pkg::LEN_W'(MAX_FRAME_WORDS)) begin
            // oversize header: report and keep hunting
            res_valid         = 1'b1;
            res.kind          = sfd_pkg::KIND_OVERSIZE;
            res.digital_bits  = dig_latest_r;
            res.header_length = hdr_len;
          end else if (hdr_len != '0) begin
            in_payload_nxt = 1'b1;
            words_left_nxt = hdr_len[CNT_W-1:0];
            word_pos_nxt   = '0;
            dig_accum_nxt  = '0;
          end
        end
      end else begin
        dig_accum_nxt = dig_accum_r | dig_merge;
        if (word_pos_r != 2'd3) begin
          word_pos_nxt = word_pos_r + 2'd1;
        end
        if (words_left_r != '0) begin
          words_left_nxt = words_left_r - CNT_W'(1);
        end
        if (last) begin
          dig_latest_nxt = dig_accum_nxt;
          in_payload_nxt = 1'b0;
          word_pos_nxt   = '0;
        end
        res_valid        = 1'b1;
        res.kind         = sfd_pkg::KIND_SAMPLE;
        res.sample_value = word[sfd_pkg::SAMPLE_W-1:0];
        res.frame_last   = last;
        res.digital_bits = dig_latest_nxt;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      words_left_r <= '0;
      word_pos_r   <= '0;
      dig_accum_r  <= '0;
      dig_latest_r <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      words_left_r <= words_left_nxt;
      word_pos_r   <= word_pos_nxt;
      dig_accum_r  <= dig_accum_nxt;
      dig_latest_r <= dig_latest_nxt;
    end
  end

endmodule

### rtl/sample_frame_deframer.sv
// ----------------------------------------------------------------------------
// sample_frame_deframer: link word deframer for a data-acquisition link
// Hunts for headers, counts payload words out as 12-bit samples and reports
// oversize headers.
// ----------------------------------------------------------------------------
// One link word is taken per cycle while in_ch.ready is high, and its result (if any)
// appears in the output register in the next cycle. A header word with bit 15
// set opens a frame of the length in its low 12 bits; the following words are
// passed out as samples, the final one flagged with frame_last. Headers longer
// than MAX_FRAME_WORDS yield one kind-1 beat carrying the length; zero-length
// headers and non-header words while hunting yield nothing. digital_bits
// carries the digital-input byte built from bits 14:12 of the first two words
// and bits 14:13 of the third of the most recently completed frame. in_ch.ready
// is low only while the output register holds a beat that the sink is not taking.
// ----------------------------------------------------------------------------
module sample_frame_deframer #(
  parameter int unsigned MAX_FRAME_WORDS = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch
);

  logic             accept;
  logic             res_valid;
  sfd_pkg::result_t res;
  logic             out_valid_r;
  sfd_pkg::result_t out_data_r;

  // input beat is taken whenever the output register can be refilled
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sfd_frame_ctrl #(
    .MAX_FRAME_WORDS (MAX_FRAME_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .word      (in_ch.link_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_data_r.kind;
  assign out_ch.sample_value  = out_data_r.sample_value;
  assign out_ch.frame_last    = out_data_r.frame_last;
  assign out_ch.digital_bits  = out_data_r.digital_bits;
  assign out_ch.header_length = out_data_r.header_length;

endmodule
